// ===== rtl/ldpi_pkg.sv =====
// ----------------------------------------------------------------------------
// ldpi_pkg
// Shared types and constants for the log-domain parameter interpolator.
// ----------------------------------------------------------------------------
package ldpi_pkg;

  // Parameter vector depth and element index width
  localparam int ORDER  = 8;
  localparam int ELEM_W = (ORDER > 1) ? $clog2(ORDER) : 1;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int TADDR_W     = 8;

  // Arithmetic widths
  localparam int WORD_W = 16;
  localparam int ACC_W  = 18;   // rate and log-sum, signed
  localparam int HALF_W = 15;   // |diff| >> 1

  localparam logic [ACC_W-1:0]  RATE_BIAS  = ACC_W'(18'h80);
  localparam logic [WORD_W-1:0] CLAMP_HIGH = WORD_W'(16'd255);

  // Item kinds carried in s_tuser
  typedef enum logic [1:0] {
    MODE_LOAD_LOG  = 2'd0,
    MODE_LOAD_ALOG = 2'd1,
    MODE_SNAP      = 2'd2,
    MODE_STEP      = 2'd3
  } mode_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // take the input beat, start log(duration) read
    logic rd_idx;    // latch log(duration), start log(idx) read
    logic rd_mag;    // form rate, start log(|diff|/2) read
    logic rd_alog;   // form log-sum, start antilog read
    logic finish;    // commit state, load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_step;   // beat on the input is a step with a valid element
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

// ===== rtl/ldpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldpi_ctrl
// Sequencer: walks a step through its four chained table reads; other beats go straight to the commit.
// ----------------------------------------------------------------------------
module ldpi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ldpi_pkg::status_t status,
  output ldpi_pkg::cmd_t    cmd
);
  import ldpi_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_IDX  = 5'b00010,
    ST_MAG  = 5'b00100,
    ST_ALOG = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no beat is taken while reset is held
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = status.in_step ? ST_IDX : ST_FIN;
        end
      end
      ST_IDX: begin
        cmd.rd_idx = 1'b1;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.rd_mag = 1'b1;
        state_next = ST_ALOG;
      end
      ST_ALOG: begin
        cmd.rd_alog = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ldpi_dpath.sv =====
// ----------------------------------------------------------------------------
// ldpi_dpath
// Datapath: input registers, log and antilog tables, parameter vector,
// rate/step arithmetic and the output register.
// ----------------------------------------------------------------------------
module ldpi_dpath (
  input  logic               clk,
  input  logic               rst,
  input  logic [55:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,
  output logic [0:0]         m_tuser,
  input  ldpi_pkg::cmd_t     cmd,
  output ldpi_pkg::status_t  status
);
  import ldpi_pkg::*;

  // Unpacked input beat
  logic [TADDR_W-1:0] in_index;
  logic [WORD_W-1:0]  in_value;
  logic [WORD_W-1:0]  in_dur;
  logic [WORD_W-1:0]  in_tl;

  assign in_index = s_tdata[7:0];
  assign in_value = s_tdata[23:8];
  assign in_dur   = s_tdata[39:24];
  assign in_tl    = s_tdata[55:40];

  // Captured item
  mode_t              mode_r;
  logic [TADDR_W-1:0] index_r;
  logic [WORD_W-1:0]  value_r;
  logic [WORD_W-1:0]  dur_r;
  logic [WORD_W-1:0]  tl_r;
  logic               dur_big;

  // Intermediates
  logic [WORD_W-1:0]  l_dur;
  logic               idx_big;
  logic               diff_neg;
  logic [HALF_W-1:0]  half_r;
  logic [ACC_W-1:0]   rate;
  logic               sum_neg;
  logic               sum_big;

  // Tables
  logic [WORD_W-1:0]  log_mem  [TABLE_DEPTH];
  logic [WORD_W-1:0]  alog_mem [TABLE_DEPTH];
  logic [WORD_W-1:0]  log_q;
  logic [WORD_W-1:0]  alog_q;
  logic [TADDR_W-1:0] log_raddr;

  // Parameter vector
  logic [WORD_W-1:0]  param [ORDER];

  logic               elem_bad;
  logic [ELEM_W-1:0]  elem;
  logic [WORD_W-1:0]  cur;
  logic [16:0]        diff;
  logic [16:0]        mag;
  logic [11:0]        idx;
  logic [16:0]        idx_sum;
  logic [WORD_W-1:0]  l_idx;
  logic [WORD_W-1:0]  l_mag;
  logic [ACC_W-1:0]   sum;
  logic [WORD_W-1:0]  stepv;
  logic [WORD_W-1:0]  new_val;

  assign status.in_step  = (mode_t'(s_tuser) == MODE_STEP) &&
                           ({1'b0, in_index} < 9'(ORDER));
  assign status.out_free = !m_tvalid || m_tready;

  assign elem_bad = ({1'b0, index_r} >= 9'(ORDER));
  assign elem     = index_r[ELEM_W-1:0];
  assign cur      = param[elem];

  // idx = ((tl - tl/4 + dur) >> 5) + 1, at most 3584
  assign idx_sum = 17'(tl_r - {2'b00, tl_r[15:2]}) + {1'b0, dur_r};
  assign idx     = idx_sum[16:5] + 12'd1;

  assign diff = {value_r[15], value_r} - {cur[15], cur};
  assign mag  = diff[16] ? (17'd0 - diff) : diff;

  assign l_idx = idx_big ? CLAMP_HIGH : log_q;
  assign l_mag = (|half_r[HALF_W-1:8]) ? CLAMP_HIGH : log_q;
  assign sum   = {{(ACC_W-WORD_W){l_mag[15]}}, l_mag} + rate;

  assign stepv   = sum_neg ? '0 : (sum_big ? CLAMP_HIGH : alog_q);
  assign new_val = diff_neg ? (cur - stepv) : (cur + stepv);

  always_comb begin
    log_raddr = dur_r[7:0];
    if (cmd.capture) begin
      log_raddr = in_dur[7:0];
    end else if (cmd.rd_idx) begin
      log_raddr = idx[7:0];
    end else if (cmd.rd_mag) begin
      log_raddr = half_r[7:0];
    end
  end

  // Log table: one read, one write port
  always_ff @(posedge clk) begin
    log_q <= log_mem[log_raddr];
    if (cmd.finish && mode_r == MODE_LOAD_LOG) begin
      log_mem[index_r] <= value_r;
    end
  end

  // Antilog table; read word held while the commit waits
  always_ff @(posedge clk) begin
    if (cmd.rd_alog) begin
      alog_q <= alog_mem[sum[7:0]];
    end
    if (cmd.finish && mode_r == MODE_LOAD_ALOG) begin
      alog_mem[index_r] <= value_r;
    end
  end

  // Item pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= mode_t'(s_tuser);
      index_r <= in_index;
      value_r <= in_value;
      dur_r   <= in_dur;
      tl_r    <= in_tl;
      dur_big <= |in_dur[15:8];
    end
    if (cmd.rd_idx) begin
      l_dur    <= dur_big ? CLAMP_HIGH : log_q;
      idx_big  <= |idx[11:8];
      diff_neg <= diff[16];
      half_r   <= mag[HALF_W:1];
    end
    if (cmd.rd_mag) begin
      rate <= {{(ACC_W-WORD_W){l_dur[15]}}, l_dur}
            - {{(ACC_W-WORD_W){l_idx[15]}}, l_idx} - RATE_BIAS;
    end
    if (cmd.rd_alog) begin
      sum_neg <= sum[ACC_W-1];
      sum_big <= !sum[ACC_W-1] && (|sum[ACC_W-2:8]);
    end
  end

  // Parameter vector
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) begin
        param[i] <= '0;
      end
    end else if (cmd.finish && !elem_bad) begin
      if (mode_r == MODE_SNAP) begin
        param[elem] <= value_r;
      end else if (mode_r == MODE_STEP) begin
        param[elem] <= new_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (mode_r) inside
        MODE_LOAD_LOG, MODE_LOAD_ALOG: begin
          m_tdata <= value_r;
          m_tuser <= 1'b0;
        end
        MODE_SNAP: begin
          m_tdata <= elem_bad ? '0 : value_r;
          m_tuser <= elem_bad;
        end
        default: begin
          m_tdata <= elem_bad ? '0 : new_val;
          m_tuser <= elem_bad;
        end
      endcase
    end
  end

endmodule

// ===== rtl/log_domain_parameter_interpolator.sv =====
// ----------------------------------------------------------------------------
// log_domain_parameter_interpolator
// Moves a vector of synthesiser parameters toward targets in the log domain.
//
//  channel | dir | fields (lowest bit up)
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | tdata: index[7:0] value[23:8] duration[39:24]
//          |     |        time_left[55:40]; tuser: mode[1:0]
//  m_*     | out | tdata: element_value[15:0]; tuser: index_error[0]
//
// Sequence: a step beat is accepted, then its log(duration), log(idx),
// log(|diff|/2) and antilog reads are chained through the one registered
// read port of each table before the commit; loads, snaps and steps on an
// element outside the vector go from acceptance straight to the commit.
// Reset clears the parameter vector and the handshake; the tables hold
// whatever was last loaded and must be loaded before any step reads them.
// A result sits in the output register; the next beat is accepted while it
// waits, and only the final commit stalls until m_tready drains it.
// ----------------------------------------------------------------------------
module log_domain_parameter_interpolator (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // index, value, duration, time_left
  input  logic [1:0]  s_tuser,   // mode
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // element_value
  output logic [0:0]  m_tuser    // index_error
);
  import ldpi_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  ldpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Tables, parameter vector, arithmetic and output register
  ldpi_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ===== dv/ldpi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpi_checker
// Watches both streams of the interpolator, keeps its own copy of the tables
// and the parameter vector, and compares every result beat against the
// oldest predicted element value and error flag.
// ----------------------------------------------------------------------------
module ldpi_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // index, value, duration, time_left
  input  logic [1:0]  s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // element_value
  input  logic [0:0]  m_tuser,   // index_error
  output int          fail_count,
  output int          pending
);
  import ldpi_pkg::*;

  localparam int STEP_BIAS = 'h80;
  localparam int LUT_TOP   = 255;

  typedef struct {
    logic [15:0] value;
    logic        err;
  } outcome_t;

  logic [15:0] log_words  [256];
  logic [15:0] alog_words [256];
  logic [15:0] elem_values [ORDER];
  outcome_t    outcome_q [$];

  initial begin
    for (int a = 0; a < 256; a++) begin
      log_words[a]  = '0;
      alog_words[a] = '0;
    end
    fail_count = 0;
    pending    = 0;
  end

  // out-of-range addresses give the clamp value, not a table read
  function automatic int table_read(input bit antilog, input int x);
    logic [15:0] w;
    if (x < 0) return 0;
    if (x > LUT_TOP) return LUT_TOP;
    w = antilog ? alog_words[x] : log_words[x];
    return int'($signed(w));
  endfunction

  function automatic outcome_t apply_beat(input mode_t kind, input logic [7:0] slot,
                                          input logic [15:0] word, input logic [15:0] dur,
                                          input logic [15:0] left);
    outcome_t    r;
    int          frames, remain, span, rate, diff, mag, stride;
    logic [15:0] cur;
    r.value = '0;
    r.err   = 1'b0;
    case (kind)
      MODE_LOAD_LOG: begin
        log_words[slot] = word;
        r.value = word;
      end
      MODE_LOAD_ALOG: begin
        alog_words[slot] = word;
        r.value = word;
      end
      default: begin
        if (int'(slot) >= ORDER) begin
          r.err = 1'b1;
        end else if (kind == MODE_SNAP) begin
          elem_values[slot] = word;
          r.value = word;
        end else begin
          frames = int'(dur);
          remain = int'(left);
          span   = ((remain - (remain >>> 2) + frames) >>> 5) + 1;
          rate   = table_read(1'b0, frames) - table_read(1'b0, span) - STEP_BIAS;
          cur    = elem_values[slot];
          diff   = int'($signed(word)) - int'($signed(cur));
          mag    = (diff < 0) ? -diff : diff;
          stride = table_read(1'b1, table_read(1'b0, mag >>> 1) + rate);
          if (diff < 0) cur = cur - stride[15:0];
          else cur = cur + stride[15:0];
          elem_values[slot] = cur;
          r.value = cur;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    int       misses;
    misses = 0;
    if (rst) begin
      for (int e = 0; e < ORDER; e++) elem_values[e] = '0;
      outcome_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        outcome_q.push_back(apply_beat(mode_t'(s_tuser), s_tdata[7:0], s_tdata[23:8],
                                       s_tdata[39:24], s_tdata[55:40]));
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat %h err %b with nothing expected", $time, m_tdata,
                   m_tuser[0]);
          misses = 1;
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: element_value expected %h got %h", $time, want.value, m_tdata);
            misses++;
          end
          if (m_tuser[0] !== want.err) begin
            $display("%0t: index_error expected %b got %b", $time, want.err, m_tuser[0]);
            misses++;
          end
        end
      end
    end
    fail_count <= fail_count + misses;
    pending    <= outcome_q.size();
  end

endmodule

// ===== dv/log_domain_parameter_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_domain_parameter_interpolator_tb
// Loads both lookup tables in full, then drives directed and random snap,
// step and load beats under changing idle and stall patterns; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module log_domain_parameter_interpolator_tb;
  import ldpi_pkg::*;

  localparam int LIMIT        = 1_000_000;  // watchdog, in clock cycles
  localparam int HOLD_CYCLES  = 400;        // one long result-side hold-off
  localparam int RANDOM_BEATS = 1219;       // table fill and directed beats make ~1750
  localparam int PHASE_BEATS  = 250;
  localparam int DRAIN_CYCLES = 20;         // drain margin after the checker queue empties

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_phase_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   hold_left     = 0;
  logic hold_req      = 1'b0;
  logic hold_done     = 1'b0;
  int   cycles        = 0;
  int   fail_count;
  int   pending;

  always #5 clk = ~clk;

  log_domain_parameter_interpolator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // index, value, duration, time_left
    .s_tuser  (s_tuser),    // mode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // element_value
    .m_tuser  (m_tuser)     // index_error
  );

  ldpi_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls, plus a single long hold-off once requested.
  // The sender keeps offering beats meanwhile, so the block backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
      m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic set_phase(input idle_phase_t p);
    src_idle_pct  = (p == IDLE_SRC) ? 73 : (p == IDLE_BOTH) ? 32 : 0;
    snk_stall_pct <= (p == IDLE_SNK) ? 73 : (p == IDLE_BOTH) ? 32 : 0;
  endtask

  // Offer one beat, with random gaps first; returns at the accepting edge.
  task automatic send_beat(input mode_t kind, input logic [7:0] slot, input logic [15:0] word,
                           input logic [15:0] dur, input logic [15:0] left);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {left, dur, word, slot};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  // Log words mostly small so log sums land inside the antilog table;
  // some negative and some anywhere to reach both clamps.
  function automatic logic [15:0] log_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 300));
    if (r < 85) return 16'(-$urandom_range(1, 400));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] alog_word();
    if ($urandom_range(0, 1) != 0) return 16'($urandom_range(0, 2047));
    return 16'($urandom);
  endfunction

  // Element number: mostly valid, sometimes out of the vector
  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, ORDER - 1));
    return 8'($urandom_range(ORDER, 255));
  endfunction

  // Short durations read the log table directly; long ones clamp
  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 255));
    if (r < 90) return 16'($urandom_range(256, 2047));
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int          r;
    logic [15:0] dur;
    logic [15:0] left;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Fill both tables first so that no step ever reads an empty entry;
    // the fill itself runs through all four idle patterns.
    for (int a = 0; a < 256; a++) begin
      set_phase(idle_phase_t'(a / 64));
      send_beat(MODE_LOAD_LOG, 8'(a), log_word(), 16'($urandom), 16'($urandom));
    end
    for (int a = 0; a < 256; a++) begin
      set_phase(idle_phase_t'(a / 64));
      send_beat(MODE_LOAD_ALOG, 8'(a), alog_word(), 16'($urandom), 16'($urandom));
    end

    // Directed beats: field extremes, every mode, both clamps, bad elements
    set_phase(IDLE_NONE);
    send_beat(MODE_LOAD_ALOG, 8'd0,   16'h7fff, 16'h0000, 16'h0000);
    send_beat(MODE_LOAD_ALOG, 8'd255, 16'h8000, 16'hffff, 16'hffff);
    send_beat(MODE_LOAD_LOG,  8'd255, 16'hffff, 16'h0000, 16'h0000);
    send_beat(MODE_SNAP,      8'd0,   16'h7fff, 16'h0000, 16'h0000);
    send_beat(MODE_SNAP,      8'd7,   16'h8000, 16'h0000, 16'h0000);
    send_beat(MODE_SNAP,      8'd8,   16'h1234, 16'h0000, 16'h0000);
    send_beat(MODE_SNAP,      8'd255, 16'hffff, 16'hffff, 16'hffff);
    // full-scale distance, both timing fields saturating
    send_beat(MODE_STEP,      8'd0,   16'h8000, 16'hffff, 16'hffff);
    send_beat(MODE_STEP,      8'd7,   16'h7fff, 16'h0000, 16'h0000);
    send_beat(MODE_STEP,      8'd8,   16'h0000, 16'h0010, 16'h0008);
    send_beat(MODE_STEP,      8'd255, 16'h7fff, 16'hffff, 16'h0000);
    send_beat(MODE_STEP,      8'd2,   16'h0100, 16'd255,  16'd255);
    send_beat(MODE_STEP,      8'd5,   16'hff00, 16'd1,    16'd0);
    // very negative log word: antilog address goes below zero
    send_beat(MODE_LOAD_LOG,  8'd0,   16'h8000, 16'h0000, 16'h0000);
    send_beat(MODE_STEP,      8'd3,   16'h0000, 16'd40,   16'd20);
    // very large log word: antilog address goes above the table
    send_beat(MODE_LOAD_LOG,  8'd1,   16'h7fff, 16'h0000, 16'h0000);
    send_beat(MODE_STEP,      8'd4,   16'h0003, 16'd100,  16'd50);
    send_beat(MODE_STEP,      8'd4,   16'hfffd, 16'd100,  16'd0);
    send_beat(MODE_STEP,      8'd6,   16'h4000, 16'd300,  16'd1000);

    // Long hold-off on the result side at the start of the random part
    hold_req <= 1'b1;

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      set_phase(idle_phase_t'((n / PHASE_BEATS) % 4));
      r    = $urandom_range(0, 99);
      dur  = pick_duration();
      left = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, dur)) : 16'($urandom);
      if (r < 8)
        send_beat(MODE_LOAD_LOG, 8'($urandom), log_word(), dur, left);
      else if (r < 16)
        send_beat(MODE_LOAD_ALOG, 8'($urandom), alog_word(), dur, left);
      else if (r < 32)
        send_beat(MODE_SNAP, pick_slot(), 16'($urandom), dur, left);
      else
        send_beat(MODE_STEP, pick_slot(), 16'($urandom), dur, left);
    end
    s_tvalid <= 1'b0;

    // Let the last prediction land, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ldpi_pkg.sv
rtl/ldpi_ctrl.sv
rtl/ldpi_dpath.sv
rtl/log_domain_parameter_interpolator.sv
dv/ldpi_checker.sv
dv/log_domain_parameter_interpolator_tb.sv
